>>> rtl/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared constants for the counting Bloom filter counter table: table
// geometry, cell limits, register map and request codes.
// ----------------------------------------------------------------------------
package cbf_pkg;

  // Table geometry
  localparam int INDEX_BITS  = 12;
  localparam int CELL_DEPTH  = 1 << INDEX_BITS;
  localparam int SHIFT_W     = $clog2(INDEX_BITS + 1);

  // Cell and counter widths
  localparam int CELL_W      = 16;
  localparam int OVF_W       = 32;
  localparam int TOTAL_W     = 32;
  localparam int CELLS_W     = 13;

  // Cell saturation limits
  localparam logic [CELL_W-1:0] NARROW_MAX = 16'd255;
  localparam logic [CELL_W-1:0] WIDE_MAX   = 16'd65535;

  // Register map (word index within the APB window)
  localparam int                PADDR_W        = 4;
  localparam logic [1:0]        REG_INDEX_BITS = 2'd0;
  localparam logic [1:0]        REG_WIDE_CELLS = 2'd1;
  localparam logic [1:0]        REG_BIG_ENDIAN = 2'd2;

  // Register reset values
  localparam logic [3:0]        INDEX_BITS_RST = 4'd12;

  // Request kinds carried in tuser
  localparam logic              REQ_INSERT = 1'b0;
  localparam logic              REQ_CHECK  = 1'b1;

  // Stream widths
  localparam int                IN_DATA_W  = 48;
  localparam int                OUT_DATA_W = 128;

endpackage

>>> rtl/counting_bloom_filter_table_core.sv
// ----------------------------------------------------------------------------
// counting_bloom_filter_table_core
// Counter table of a counting Bloom filter: per insert run a read-modify-write
// of one saturating cell and its overflow count (check runs only read), with running totals.
// ----------------------------------------------------------------------------
// Result: registered when the update of the last run of an element ends; that
//   update waits while the previous result has not been taken. Each hash run takes a
//   memory read step, then a modify and write-back step on the same memories.
// Reset: rst clears control state and totals, then a clearing pass writes zero to
//   all 4096 cells, one per cycle; no run is accepted meanwhile.
// ----------------------------------------------------------------------------
module counting_bloom_filter_table_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cbf_pkg::PADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // Hash run input
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: digest_bits[31:0], multiplicity[47:32]
  input  logic [cbf_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // tuser: req_type[0]
  input  logic                                 s_axis_tuser,
  input  logic                                 s_axis_tlast,
  // Result output
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: min_count[15:0], bad_multiplicity[16], element_total[48:17],
  //        member_total[80:49], overflow_total[112:81],
  //        ovf_cells[125:113], zero[127:126]
  output logic [cbf_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

  localparam int IB = cbf_pkg::INDEX_BITS;
  localparam int CW = cbf_pkg::CELL_W;
  localparam int OW = cbf_pkg::OVF_W;
  localparam int TW = cbf_pkg::TOTAL_W;
  localparam int NW = cbf_pkg::CELLS_W;

  // State codes
  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  // Configuration registers
  logic [3:0]    index_bits_used;
  logic          wide_cells;
  logic          big_endian;

  // Control
  logic [1:0]    state;
  logic [IB-1:0] clr_addr;

  // Accepted run
  logic          item_check;
  logic [15:0]   item_mult;
  logic          item_last;
  logic [IB-1:0] item_idx;

  // Memories and their registered read data
  logic [CW-1:0] cell_mem [cbf_pkg::CELL_DEPTH];
  logic [OW-1:0] ovf_mem  [cbf_pkg::CELL_DEPTH];
  logic [CW-1:0] rd_cell;
  logic [OW-1:0] rd_ovf;

  // Element and global state
  logic [CW-1:0] running_min;
  logic          error_seen;
  logic [TW-1:0] elements_seen;
  logic [TW-1:0] members_sum;
  logic [TW-1:0] overflow_sum;
  logic [NW-1:0] overflowed_cell_count;

  // Output register
  logic          out_valid;
  logic [cbf_pkg::OUT_DATA_W-1:0] out_data;

  // --------------------------------------------------------------------------
  // APB port
  // --------------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits_used <= cbf_pkg::INDEX_BITS_RST;
      wide_cells      <= 1'b0;
      big_endian      <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        cbf_pkg::REG_INDEX_BITS: index_bits_used <= pwdata[3:0];
        cbf_pkg::REG_WIDE_CELLS: wide_cells      <= pwdata[0];
        cbf_pkg::REG_BIG_ENDIAN: big_endian      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      cbf_pkg::REG_INDEX_BITS: prdata = {28'd0, index_bits_used};
      cbf_pkg::REG_WIDE_CELLS: prdata = {31'd0, wide_cells};
      cbf_pkg::REG_BIG_ENDIAN: prdata = {31'd0, big_endian};
      default:                 prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Cell index from the digest word
  // --------------------------------------------------------------------------
  localparam int SHIFT_W = cbf_pkg::SHIFT_W;

  logic [31:0]        in_digest;
  logic [31:0]        digest_word;
  logic [3:0]         ib_used;
  logic [SHIFT_W-1:0] idx_shift;
  logic [IB-1:0]      in_idx;

  assign in_digest   = s_axis_tdata[31:0];
  assign digest_word = big_endian ? in_digest
                     : {in_digest[7:0], in_digest[15:8], in_digest[23:16], in_digest[31:24]};

  always_comb begin
    // clamp the index width to the table size; zero maps to cell 0
    if (32'(index_bits_used) > IB) ib_used = 4'(IB);
    else                           ib_used = index_bits_used;
    idx_shift = SHIFT_W'(IB - int'(ib_used));
    in_idx    = digest_word[31 -: IB] >> idx_shift;
  end

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic accept;
  logic upd_done;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // a last run waits while the previous result has not been taken
  assign upd_done      = (state == ST_UPDATE) && (!item_last || !out_valid || m_axis_tready);

  // --------------------------------------------------------------------------
  // Modify stage
  // --------------------------------------------------------------------------
  logic [CW-1:0] max_val;
  logic [CW-1:0] cell_val;
  logic          is_bad;
  logic [CW:0]   cell_sum;
  logic          cell_sat;
  logic [CW:0]   excess;
  logic [CW-1:0] cell_new;
  logic [OW:0]   ovf_add;
  logic [OW-1:0] ovf_new;
  logic [TW:0]   ovf_sum_add;
  logic [TW-1:0] overflow_sum_next;
  logic [NW-1:0] overflowed_cell_count_next;
  logic          do_write;
  logic [CW-1:0] cell_eff;
  logic [CW-1:0] min_next;
  logic          error_next;
  logic          count_elem;
  logic [TW-1:0] elements_seen_next;
  logic [TW:0]   members_add;
  logic [TW-1:0] members_sum_next;

  always_comb begin
    max_val  = wide_cells ? cbf_pkg::WIDE_MAX : cbf_pkg::NARROW_MAX;
    cell_val = wide_cells ? rd_cell : {8'd0, rd_cell[7:0]};
    is_bad   = (item_check == cbf_pkg::REQ_INSERT) && (item_mult > max_val);
    do_write = (item_check == cbf_pkg::REQ_INSERT) && !is_bad;

    // saturating cell add, excess to the overflow count
    cell_sum = {1'b0, cell_val} + {1'b0, item_mult};
    cell_sat = cell_sum > {1'b0, max_val};
    excess   = cell_sum - {1'b0, max_val};
    cell_new = cell_sat ? max_val : cell_sum[CW-1:0];

    ovf_add     = {1'b0, rd_ovf} + {{(OW-CW){1'b0}}, excess};
    ovf_new     = ovf_add[OW] ? '1 : ovf_add[OW-1:0];
    ovf_sum_add = {1'b0, overflow_sum} + {{(TW-CW){1'b0}}, excess};

    overflow_sum_next          = overflow_sum;
    overflowed_cell_count_next = overflowed_cell_count;
    if (do_write && cell_sat) begin
      overflow_sum_next = ovf_sum_add[TW] ? '1 : ovf_sum_add[TW-1:0];
      if (rd_ovf == '0 && overflowed_cell_count != '1)
        overflowed_cell_count_next = overflowed_cell_count + 1'b1;
    end

    // running minimum over the element
    cell_eff   = do_write ? cell_new : cell_val;
    min_next   = (cell_eff < running_min) ? cell_eff : running_min;
    error_next = error_seen || is_bad;

    // totals on a clean last insert run
    count_elem  = item_last && do_write && !error_seen;
    members_add = {1'b0, members_sum} + {{(TW-16){1'b0}}, item_mult};
    elements_seen_next = elements_seen;
    members_sum_next   = members_sum;
    if (count_elem) begin
      if (elements_seen != '1) elements_seen_next = elements_seen + 1'b1;
      members_sum_next = members_add[TW] ? '1 : members_add[TW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Memories: one registered read, one write (update or clearing pass)
  // --------------------------------------------------------------------------
  logic          mem_we;
  logic [IB-1:0] wr_addr;
  logic [CW-1:0] wr_cell;
  logic [OW-1:0] wr_ovf;

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_addr;
      wr_cell = '0;
      wr_ovf  = '0;
    end else begin
      mem_we  = upd_done && do_write;
      wr_addr = item_idx;
      wr_cell = cell_new;
      wr_ovf  = cell_sat ? ovf_new : rd_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[wr_addr] <= wr_cell;
      ovf_mem[wr_addr]  <= wr_ovf;
    end
    if (accept) begin
      rd_cell <= cell_mem[in_idx];
      rd_ovf  <= ovf_mem[in_idx];
    end
  end

  // --------------------------------------------------------------------------
  // Run capture
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      item_check <= s_axis_tuser;
      item_mult  <= s_axis_tdata[47:32];
      item_last  <= s_axis_tlast;
      item_idx   <= in_idx;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and totals
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= ST_CLEAR;
      clr_addr              <= '0;
      running_min           <= '1;
      error_seen            <= 1'b0;
      elements_seen         <= '0;
      members_sum           <= '0;
      overflow_sum          <= '0;
      overflowed_cell_count <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (upd_done) begin
            state                 <= ST_IDLE;
            overflow_sum          <= overflow_sum_next;
            overflowed_cell_count <= overflowed_cell_count_next;
            elements_seen         <= elements_seen_next;
            members_sum           <= members_sum_next;
            if (item_last) begin
              running_min <= '1;
              error_seen  <= 1'b0;
            end else begin
              running_min <= min_next;
              error_seen  <= error_next;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result valid: a new result may replace one taken in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_done && item_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (upd_done && item_last) begin
      out_data <= {2'b00, overflowed_cell_count_next, overflow_sum_next,
                   members_sum_next, elements_seen_next, error_next, min_next};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the counting Bloom filter counter table. Hash runs
// go in on the input stream, element results are compared field by field
// with a cycle-free predictor of the cell table, overflow counts and totals.
// Runs under several index widths, cell widths and byte orders, with random
// idle bursts on both streams in all but the last test.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QUIET_LIMIT  = 20000;
  localparam int SETTLE_TICKS = 4;

  typedef struct packed {
    logic [15:0] min_count;
    logic        bad_mult;
    logic [31:0] element_total;
    logic [31:0] member_total;
    logic [31:0] overflow_total;
    logic [12:0] ovf_cells;
  } tally_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [cbf_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic s_axis_tvalid, s_axis_tready;
  logic [cbf_pkg::IN_DATA_W-1:0] s_axis_tdata;   // digest_bits[31:0], multiplicity[47:32]
  logic s_axis_tuser;                            // req_type[0]
  logic s_axis_tlast;
  logic m_axis_tvalid, m_axis_tready;
  // min_count[15:0], bad_multiplicity[16], element_total[48:17],
  // member_total[80:49], overflow_total[112:81], ovf_cells[125:113]
  logic [cbf_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // Predictor state
  logic [15:0] cell_tab [cbf_pkg::CELL_DEPTH];
  logic [31:0] ovf_tab [cbf_pkg::CELL_DEPTH];
  logic [15:0] run_min;
  logic        run_err;
  logic [31:0] elem_cnt, member_cnt, ovf_sum;
  logic [12:0] ovf_cell_cnt;
  logic [3:0]  cfg_index_bits;
  logic        cfg_wide, cfg_big_endian;

  tally_t tally_q[$];
  int     fail_count = 0;
  int     quiet_cycles = 0;
  int     rx_stall = 0;
  bit     tx_idle_en = 1'b1;
  bit     rx_idle_en = 1'b1;

  counting_bloom_filter_table_core uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Saturating 32-bit add
  function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Predict the effect of one accepted hash run
  task automatic table_update(input logic req, input logic [31:0] dig,
                              input logic [15:0] mult, input logic last);
    logic [31:0] word, excess;
    logic [11:0] idx;
    logic [16:0] lim, cell_val, sum;
    logic        bad;
    int          ib;
    tally_t      t;
    word = cfg_big_endian ? dig : {dig[7:0], dig[15:8], dig[23:16], dig[31:24]};
    ib   = (cfg_index_bits > cbf_pkg::INDEX_BITS) ? cbf_pkg::INDEX_BITS
                                                  : int'(cfg_index_bits);
    idx  = (ib == 0) ? 12'd0 : 12'(word >> (32 - ib));
    lim  = cfg_wide ? {1'b0, cbf_pkg::WIDE_MAX} : {1'b0, cbf_pkg::NARROW_MAX};
    cell_val = cfg_wide ? {1'b0, cell_tab[idx]} : {9'd0, cell_tab[idx][7:0]};
    bad = 1'b0;
    if (req == cbf_pkg::REQ_INSERT) begin
      if ({1'b0, mult} > lim) begin
        bad = 1'b1;
        run_err = 1'b1;
      end else begin
        sum = cell_val + {1'b0, mult};
        if (sum > lim) begin
          excess = 32'(sum - lim);
          if (ovf_tab[idx] == 0 && ovf_cell_cnt < 13'd8191) ovf_cell_cnt++;
          ovf_tab[idx] = add_sat32(ovf_tab[idx], excess);
          ovf_sum      = add_sat32(ovf_sum, excess);
          sum = lim;
        end
        cell_tab[idx] = sum[15:0];
        cell_val = sum;
      end
    end
    if (cell_val < {1'b0, run_min}) run_min = cell_val[15:0];
    if (last) begin
      if (req == cbf_pkg::REQ_INSERT && !bad && !run_err) begin
        elem_cnt   = add_sat32(elem_cnt, 32'd1);
        member_cnt = add_sat32(member_cnt, {16'd0, mult});
      end
      t.min_count      = run_min;
      t.bad_mult       = run_err;
      t.element_total  = elem_cnt;
      t.member_total   = member_cnt;
      t.overflow_total = ovf_sum;
      t.ovf_cells      = ovf_cell_cnt;
      tally_q.push_back(t);
      run_min = 16'hFFFF;
      run_err = 1'b0;
    end
  endtask

  // Send one hash run, with an occasional idle burst first
  task automatic send_run(input logic req, input logic [31:0] dig,
                          input logic [15:0] mult, input logic last);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mult, dig};
    s_axis_tuser  <= req;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    table_update(req, dig, mult, last);
  endtask

  // Hold off the sender until every pending result has arrived
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // APB register write: setup then access phase
  task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_idx)
      cbf_pkg::REG_INDEX_BITS: cfg_index_bits = val[3:0];
      cbf_pkg::REG_WIDE_CELLS: cfg_wide       = val[0];
      cbf_pkg::REG_BIG_ENDIAN: cfg_big_endian = val[0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] ib, input logic wide, input logic be);
    wait_quiet();
    apb_write(cbf_pkg::REG_INDEX_BITS, {28'd0, ib});
    apb_write(cbf_pkg::REG_WIDE_CELLS, {31'd0, wide});
    apb_write(cbf_pkg::REG_BIG_ENDIAN, {31'd0, be});
  endtask

  // Multiplicity mix: mostly legal, some at the limit, some over it
  function automatic logic [15:0] pick_multiplicity();
    int lim;
    lim = cfg_wide ? 65535 : 255;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6: return 16'($urandom_range(0, 15));
      7, 8, 9:             return 16'($urandom_range(0, lim));
      10, 11, 12:          return 16'($urandom_range(lim - 3, lim));
      13:                  return cfg_wide ? 16'($urandom) : 16'($urandom_range(256, 65535));
      14:                  return 16'($urandom);
      default:             return ($urandom_range(0, 1) != 0) ? 16'(lim) : 16'd0;
    endcase
  endfunction

  // Random elements of one to eight runs, biased towards a few hot digests
  task automatic random_elements(input int n_runs);
    logic [31:0] hot [8];
    logic [31:0] dig;
    logic        req, last;
    int          sent, len, k;
    bit          mixed;
    foreach (hot[i]) hot[i] = $urandom;
    sent = 0;
    while (sent < n_runs) begin
      len   = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      mixed = ($urandom_range(0, 3) == 0);
      req   = 1'($urandom_range(0, 1));
      for (k = 0; k < len; k++) begin
        if (mixed) req = 1'($urandom_range(0, 1));
        dig  = ($urandom_range(0, 1) != 0) ? hot[$urandom_range(0, 7)] : 32'($urandom);
        last = (k == len - 1);
        // occasionally break the element boundary
        if ($urandom_range(0, 19) == 0) last = ~last;
        send_run(req, dig, pick_multiplicity(), last);
        sent++;
        if ($urandom_range(0, 59) == 0) wait_quiet();
      end
    end
  endtask

  // Directed runs under the reset configuration
  task automatic test_directed_defaults();
    send_run(cbf_pkg::REQ_CHECK,  32'h0000_0000, 16'd0,     1'b1);  // empty cell
    send_run(cbf_pkg::REQ_INSERT, 32'h0000_0000, 16'd0,     1'b1);
    send_run(cbf_pkg::REQ_INSERT, 32'hFFFF_FFFF, 16'd255,   1'b1);  // fill to limit
    send_run(cbf_pkg::REQ_INSERT, 32'hFFFF_FFFF, 16'd1,     1'b1);  // first overflow
    send_run(cbf_pkg::REQ_INSERT, 32'hFFFF_FFFF, 16'd255,   1'b1);
    send_run(cbf_pkg::REQ_INSERT, 32'h1234_5678, 16'd256,   1'b1);  // just over the limit
    send_run(cbf_pkg::REQ_INSERT, 32'h1234_5678, 16'hFFFF,  1'b0);  // error carried on
    send_run(cbf_pkg::REQ_CHECK,  32'hABCD_EF01, 16'd0,     1'b1);
    send_run(cbf_pkg::REQ_INSERT, 32'h1111_1111, 16'd7,     1'b0);
    send_run(cbf_pkg::REQ_INSERT, 32'h2222_2222, 16'd7,     1'b0);
    send_run(cbf_pkg::REQ_INSERT, 32'h3333_3333, 16'd7,     1'b1);
    send_run(cbf_pkg::REQ_INSERT, 32'h4444_4444, 16'd3,     1'b0);  // mixed element
    send_run(cbf_pkg::REQ_CHECK,  32'hFFFF_FFFF, 16'd0,     1'b1);
    send_run(cbf_pkg::REQ_CHECK,  32'h5555_5555, 16'hFFFF,  1'b0);  // ignored multiplicity
    send_run(cbf_pkg::REQ_INSERT, 32'h5555_5555, 16'd5,     1'b1);
    send_run(cbf_pkg::REQ_INSERT, 32'h8000_0000, 16'd100,   1'b0);
    send_run(cbf_pkg::REQ_INSERT, 32'h7FFF_FFFF, 16'd200,   1'b1);
    send_run(cbf_pkg::REQ_INSERT, 32'h7FFF_FFFF, 16'd100,   1'b1);
  endtask

  // Wide cells, then narrow reads of the same cells
  task automatic test_cell_width();
    set_config(4'd12, 1'b1, 1'b1);
    send_run(cbf_pkg::REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_run(cbf_pkg::REQ_INSERT, 32'h0010_0000, 16'd300,  1'b1);
    set_config(4'd12, 1'b0, 1'b1);
    send_run(cbf_pkg::REQ_CHECK,  32'h0010_0000, 16'd0,    1'b1);
    send_run(cbf_pkg::REQ_INSERT, 32'h0010_0000, 16'd250,  1'b1);
  endtask

  task automatic test_byte_order();
    set_config(4'd12, 1'b0, 1'b0);
    send_run(cbf_pkg::REQ_INSERT, 32'h0000_00F0, 16'd9, 1'b1);
    send_run(cbf_pkg::REQ_INSERT, 32'h0000_0080, 16'd4, 1'b1);
    set_config(4'd12, 1'b0, 1'b1);
    send_run(cbf_pkg::REQ_CHECK,  32'hF000_0000, 16'd0, 1'b1);
  endtask

  // Zero, minimum and over-range index widths
  task automatic test_index_widths();
    set_config(4'd0, 1'b0, 1'b1);
    random_elements(15);
    set_config(4'd1, 1'b1, 1'b0);
    random_elements(15);
    set_config(4'd13, 1'b0, 1'b0);
    random_elements(15);
    set_config(4'd15, 1'b1, 1'b1);
    random_elements(15);
  endtask

  task automatic test_random_narrow();
    set_config(4'd4, 1'b0, 1'b1);
    random_elements(150);
  endtask

  task automatic test_random_wide();
    set_config(4'd2, 1'b1, 1'b0);
    random_elements(120);
  endtask

  task automatic test_random_mixed();
    repeat (4) begin
      set_config(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      random_elements(40);
    end
  endtask

  task automatic test_no_idle();
    set_config(4'd3, 1'b0, 1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_elements(80);
  endtask

  // Result receiver with random stall bursts
  always @(posedge clk) begin
    if (rx_stall != 0) rx_stall = rx_stall - 1;
    else if (rx_idle_en && $urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 11);
    m_axis_tready <= (rx_stall == 0);
  end

  // Result checker
  always @(posedge clk) begin : chk_result
    tally_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.min_count      = m_axis_tdata[15:0];
      got.bad_mult       = m_axis_tdata[16];
      got.element_total  = m_axis_tdata[48:17];
      got.member_total   = m_axis_tdata[80:49];
      got.overflow_total = m_axis_tdata[112:81];
      got.ovf_cells      = m_axis_tdata[125:113];
      if (tally_q.size() == 0) begin
        note_failure($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        want = tally_q.pop_front();
        if (got.min_count !== want.min_count || got.bad_mult !== want.bad_mult ||
            got.element_total !== want.element_total ||
            got.member_total !== want.member_total ||
            got.overflow_total !== want.overflow_total ||
            got.ovf_cells !== want.ovf_cells)
          note_failure($sformatf(
            {"exp min=%0d bad=%0d elem=%0d memb=%0d ovf=%0d cells=%0d | ",
             "got min=%0d bad=%0d elem=%0d memb=%0d ovf=%0d cells=%0d"},
            want.min_count, want.bad_mult, want.element_total, want.member_total,
            want.overflow_total, want.ovf_cells,
            got.min_count, got.bad_mult, got.element_total, got.member_total,
            got.overflow_total, got.ovf_cells));
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= cbf_pkg::REQ_INSERT;
    s_axis_tlast  <= 1'b0;
    foreach (cell_tab[i]) begin
      cell_tab[i] = '0;
      ovf_tab[i]  = '0;
    end
    run_min        = 16'hFFFF;
    run_err        = 1'b0;
    elem_cnt       = '0;
    member_cnt     = '0;
    ovf_sum        = '0;
    ovf_cell_cnt   = '0;
    cfg_index_bits = cbf_pkg::INDEX_BITS_RST;
    cfg_wide       = 1'b0;
    cfg_big_endian = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_defaults();
    test_cell_width();
    test_byte_order();
    test_index_widths();
    test_random_narrow();
    test_random_wide();
    test_random_mixed();
    test_no_idle();

    s_axis_tvalid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cbf_pkg.sv
rtl/counting_bloom_filter_table_core.sv
sim/testbench.sv
